>>> hdl/swle_pkg.sv
package swle_pkg;

   // Word and channel geometry
   localparam int BYTES_PER_WORD = 3;
   localparam int WORD_BITS      = BYTES_PER_WORD * 8;
   localparam int BITS_WIDTH     = $clog2(WORD_BITS + 1);
   localparam int NUM_CHANNELS   = 8;
   localparam int CH_FIELD_WIDTH = 4;
   localparam int CH_SEL_WIDTH   = 3;
   localparam int CH_MASK_WIDTH  = 8;
   localparam int TICK_WIDTH     = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Timing register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ONE_HIGH  = 2'd0,
      CSR_ONE_LOW   = 2'd1,
      CSR_ZERO_HIGH = 2'd2,
      CSR_ZERO_LOW  = 2'd3
   } csr_index_type;

   // Timing reset values
   localparam logic [TICK_WIDTH-1:0] ONE_HIGH_RESET  = 16'd16;
   localparam logic [TICK_WIDTH-1:0] ONE_LOW_RESET   = 16'd9;
   localparam logic [TICK_WIDTH-1:0] ZERO_HIGH_RESET = 16'd8;
   localparam logic [TICK_WIDTH-1:0] ZERO_LOW_RESET  = 16'd17;

   typedef struct packed {
      logic                      req_type;
      logic [WORD_BITS-1:0]      color_word;
      logic [CH_FIELD_WIDTH-1:0] channel;
   } req_payload_type;

   typedef struct packed {
      logic                     pin_level;
      logic [CH_MASK_WIDTH-1:0] channel_enable;
      logic                     busy_res;
      logic                     accepted;
      logic                     frame_done;
   } rsp_payload_type;

   // Classified request as held in the queue
   typedef struct packed {
      logic                    is_tick;
      logic                    ch_ok;
      logic [CH_SEL_WIDTH-1:0] ch_sel;
      logic [WORD_BITS-1:0]    word;
   } cmd_type;

endpackage

>>> hdl/single_wire_led_bit_encoder.sv
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid/req_ready    req_payload (req_type, color_word, channel)
//  rsp       out        rsp_valid/rsp_ready    rsp_payload (pin_level .. frame_done)
//  csr       in         csr_we                 csr_index, csr_wdata
//
//  One request per cycle sustained while the response is not stalled; each request
//  yields one response. A request is registered in the two-entry command queue, then
//  in the frame engine's result register, loaded as the command leaves the queue.
//  Synchronous reset clears queue, frame state and response valid, and loads
//  the default bit timings.
//  A stalled response holds the engine; the queue keeps taking requests until full.
module single_wire_led_bit_encoder #(
   parameter int QUEUE_DEPTH = swle_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  swle_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output swle_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_we,
   input  logic [swle_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [swle_pkg::TICK_WIDTH-1:0]      csr_wdata
);

   logic              push, queue_full, pop, queue_not_empty;
   swle_pkg::cmd_type push_cmd, pop_cmd;

   // Accept and classify requests
   swle_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Buffer classified requests
   swle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_cmd   (pop_cmd)
   );

   // Run the waveform engine
   swle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd_valid   (queue_not_empty),
      .cmd         (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hdl/swle_front.sv
module swle_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  swle_pkg::req_payload_type req_payload,
   input  logic                      queue_full,
   output logic                      push,
   output swle_pkg::cmd_type         push_cmd
);

   logic [swle_pkg::CH_FIELD_WIDTH-1:0] ch_minus_one;

   // Take a request whenever the queue has room
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Classify: request kind, channel range, channel select
   assign ch_minus_one = req_payload.channel - swle_pkg::CH_FIELD_WIDTH'(1);

   always_comb begin
      push_cmd.is_tick = (req_payload.req_type == swle_pkg::REQ_TICK);
      push_cmd.ch_ok   = (req_payload.channel >= swle_pkg::CH_FIELD_WIDTH'(1)) &&
                         (req_payload.channel <=
                          swle_pkg::CH_FIELD_WIDTH'(swle_pkg::NUM_CHANNELS));
      push_cmd.ch_sel  = ch_minus_one[swle_pkg::CH_SEL_WIDTH-1:0];
      push_cmd.word    = req_payload.color_word;
   end

endmodule

>>> hdl/swle_queue.sv
module swle_queue #(
   parameter int DEPTH = swle_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swle_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output swle_pkg::cmd_type pop_cmd
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   swle_pkg::cmd_type       entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;

   assign full      = (count_ff == COUNT_WIDTH'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hdl/swle_back.sv
module swle_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [swle_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [swle_pkg::TICK_WIDTH-1:0]      csr_wdata,
   input  logic                                 cmd_valid,
   input  swle_pkg::cmd_type                    cmd,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output swle_pkg::rsp_payload_type            rsp_payload
);

   localparam int TW = swle_pkg::TICK_WIDTH;
   localparam int BW = swle_pkg::BITS_WIDTH;
   localparam int WB = swle_pkg::WORD_BITS;

   // Timing registers
   logic [TW-1:0] t1_hi_ff, t1_lo_ff, t0_hi_ff, t0_lo_ff;

   // Frame state
   logic [WB-1:0]                     shift_ff, shift_in;
   logic [BW-1:0]                     bits_ff, bits_in;
   logic                              low_ff, low_in;
   logic [TW-1:0]                     phase_ff, phase_in;
   logic                              sending_ff, sending_in;
   logic [swle_pkg::CH_SEL_WIDTH-1:0] sel_ff, sel_in;

   // Result register
   logic                      rsp_valid_ff;
   swle_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic          cur_bit;
   logic [TW-1:0] phase_len;
   logic [TW:0]   phase_next;
   logic          phase_end;
   logic [BW-1:0] bits_dec;
   logic          pin, acc, done;

   assign pop         = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Pick the length of the phase in progress
   assign cur_bit    = shift_ff[WB-1];
   assign phase_len  = low_ff ? (cur_bit ? t1_lo_ff : t0_lo_ff)
                              : (cur_bit ? t1_hi_ff : t0_hi_ff);
   assign phase_next = {1'b0, phase_ff} + (TW+1)'(1);
   assign phase_end  = (phase_next >= {1'b0, phase_len});
   assign bits_dec   = (bits_ff != '0) ? bits_ff - BW'(1) : '0;

   // Execute one command
   always_comb begin
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      low_in     = low_ff;
      phase_in   = phase_ff;
      sending_in = sending_ff;
      sel_in     = sel_ff;
      pin        = 1'b0;
      acc        = 1'b0;
      done       = 1'b0;
      if (!cmd.is_tick) begin
         // Start a frame unless one is running
         if (!sending_ff) begin
            if (cmd.ch_ok) begin
               sel_in = cmd.ch_sel;
            end
            shift_in   = cmd.word;
            bits_in    = BW'(WB);
            low_in     = 1'b0;
            phase_in   = '0;
            sending_in = 1'b1;
            acc        = 1'b1;
         end
      end else if (sending_ff) begin
         pin = !low_ff;
         if (!phase_end) begin
            phase_in = phase_next[TW-1:0];
         end else if (!low_ff) begin
            low_in   = 1'b1;
            phase_in = '0;
         end else begin
            // Low phase over: drop the sent bit
            low_in   = 1'b0;
            phase_in = '0;
            shift_in = {shift_ff[WB-2:0], 1'b0};
            bits_in  = bits_dec;
            if (bits_dec == '0) begin
               sending_in = 1'b0;
               done       = 1'b1;
            end
         end
      end
      rsp_in.pin_level      = pin;
      rsp_in.channel_enable = swle_pkg::CH_MASK_WIDTH'(1) << sel_in;
      rsp_in.busy_res       = sending_in;
      rsp_in.accepted       = acc;
      rsp_in.frame_done     = done;
   end

   // Hold timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_hi_ff <= swle_pkg::ONE_HIGH_RESET;
         t1_lo_ff <= swle_pkg::ONE_LOW_RESET;
         t0_hi_ff <= swle_pkg::ZERO_HIGH_RESET;
         t0_lo_ff <= swle_pkg::ZERO_LOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            swle_pkg::CSR_ONE_HIGH:  t1_hi_ff <= csr_wdata;
            swle_pkg::CSR_ONE_LOW:   t1_lo_ff <= csr_wdata;
            swle_pkg::CSR_ZERO_HIGH: t0_hi_ff <= csr_wdata;
            swle_pkg::CSR_ZERO_LOW:  t0_lo_ff <= csr_wdata;
         endcase
      end
   end

   // Advance frame state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_ff      <= '0;
         low_ff       <= 1'b0;
         phase_ff     <= '0;
         sending_ff   <= 1'b0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            shift_ff   <= shift_in;
            bits_ff    <= bits_in;
            low_ff     <= low_in;
            phase_ff   <= phase_in;
            sending_ff <= sending_in;
            sel_ff     <= sel_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> hdl/swle_checker.sv
module swle_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input swle_pkg::rsp_payload_type rsp_payload
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Channel mask always selects exactly one channel
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_payload.channel_enable))
      else $error("channel enable not one-hot");

   // A taken load starts a frame and drives no line level
   a_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.accepted |->
         rsp_payload.busy_res && !rsp_payload.pin_level && !rsp_payload.frame_done)
      else $error("accepted load with bad status");

   // Frame end leaves the line low and the block idle
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |->
         !rsp_payload.busy_res && !rsp_payload.pin_level)
      else $error("frame done while busy or high");

   // Reset empties the response side
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind single_wire_led_bit_encoder swle_checker u_swle_checker (.*);
